>>> hw/rtl/mp2d_pkg.sv
package mp2d_pkg;

  localparam int MP_MAX_KERNEL = 8;
  localparam int MP_MAX_WIDTH  = 1024;
  localparam int MP_MAX_HEIGHT = 1024;
  localparam int MP_VALUE_BITS = 16;

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 11;
  localparam int KSZ_W  = 4;
  localparam int STR_W  = 4;
  localparam int DIM_W  = 11;

  localparam logic [CFG_AW-1:0] REG_KERNEL = 2'd0;
  localparam logic [CFG_AW-1:0] REG_STRIDE = 2'd1;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd2;
  localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd3;

  // result fields
  localparam int IDX_W = 32;
  localparam int ORC_W = 10;

  // reciprocal of the stride, scaled by 2^RECIP_SH
  localparam int RECIP_W  = 17;
  localparam int RECIP_SH = 16;

  typedef struct packed {
    logic valid;
    logic row_ok;
    logic col_ok;
    logic plane_end;
  } mp2d_ctrl_t;

  function automatic logic [RECIP_W-1:0] stride_recip(input logic [STR_W-1:0] s);
    logic [RECIP_W-1:0] r;
    unique case (s)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21845;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13107;
      4'd6:    r = 17'd10922;
      4'd7:    r = 17'd9362;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7281;
      4'd10:   r = 17'd6553;
      4'd11:   r = 17'd5957;
      4'd12:   r = 17'd5461;
      4'd13:   r = 17'd5041;
      4'd14:   r = 17'd4681;
      default: r = 17'd4369;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/mp2d_lbuf.sv
module mp2d_lbuf import mp2d_pkg::*; #(
  parameter int MAX_KERNEL = MP_MAX_KERNEL,
  parameter int MAX_WIDTH  = MP_MAX_WIDTH,
  parameter int VALUE_BITS = MP_VALUE_BITS,
  localparam int SLW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
  localparam int CW  = $clog2(MAX_WIDTH)
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [SLW-1:0]                        wslot,
  input  logic [CW-1:0]                         addr,
  input  logic [VALUE_BITS-1:0]                 wdata,
  input  logic                                  re,
  output logic [MAX_KERNEL-1:0][VALUE_BITS-1:0] rdata
);

  // one bank per row slot, all banks read at the same column
  logic [VALUE_BITS-1:0] mem [MAX_KERNEL][MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wslot][addr] <= wdata;
    end
    if (re) begin
      for (int b = 0; b < MAX_KERNEL; b++) begin
        rdata[b] <= mem[b][addr];
      end
    end
  end

endmodule

>>> hw/rtl/mp2d_reduce.sv
module mp2d_reduce import mp2d_pkg::*; #(
  parameter int MAX_KERNEL = MP_MAX_KERNEL,
  parameter int MAX_WIDTH  = MP_MAX_WIDTH,
  parameter int MAX_HEIGHT = MP_MAX_HEIGHT,
  parameter int VALUE_BITS = MP_VALUE_BITS,
  localparam int SLW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
  localparam int KW  = $clog2(MAX_KERNEL + 1),
  localparam int RW  = $clog2(MAX_HEIGHT),
  localparam int CW  = $clog2(MAX_WIDTH),
  localparam int WW  = $clog2(MAX_WIDTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mp2d_ctrl_t                   in_ctrl,
  input  logic signed [VALUE_BITS-1:0] in_val,
  input  logic [SLW-1:0]               in_vrow,
  input  logic [RW-1:0]                in_trow,
  input  logic [CW-1:0]                in_tcol,
  input  logic [KW-1:0]                in_k,
  input  logic [STR_W-1:0]             in_s,
  input  logic [WW-1:0]                in_w,
  input  logic [IDX_W-1:0]             in_cnt,
  output logic                         adv,
  output logic                         o_valid,
  input  logic                         o_ready,
  output logic [VALUE_BITS-1:0]        o_val,
  output logic [IDX_W-1:0]             o_idx,
  output logic [ORC_W-1:0]             o_row,
  output logic [ORC_W-1:0]             o_col,
  output logic                         o_last
);

  // column maxima of the current row, newest at index 0
  logic signed [VALUE_BITS-1:0] colv [MAX_KERNEL];
  logic [SLW-1:0]               colr [MAX_KERNEL];

  mp2d_ctrl_t         s2_ctrl, s3_ctrl, s4_ctrl;
  logic [RW-1:0]      s2_trow, s3_trow, s3_qr, s4_qr;
  logic [CW-1:0]      s2_tcol, s3_tcol, s3_qc, s4_qc;
  logic [KW-1:0]      s2_k, s3_k, s4_k;
  logic [STR_W-1:0]   s2_s, s3_s, s4_s;
  logic [WW-1:0]      s2_w, s3_w, s4_w;
  logic [IDX_W-1:0]   s2_cnt, s3_cnt, s4_cnt;
  logic signed [VALUE_BITS-1:0] s3_best, s4_best;
  logic [SLW-1:0]     s3_wr, s4_wr, s3_wc, s4_wc;
  logic [RW+STR_W-1:0] s4_remr;
  logic [CW+STR_W-1:0] s4_remc;

  logic signed [VALUE_BITS-1:0] best;
  logic [SLW-1:0]     best_r, best_c;
  logic [RW+RECIP_W-1:0] qr_full;
  logic [CW+RECIP_W-1:0] qc_full;
  logic [RW+STR_W-1:0] prod_r, remr;
  logic [CW+STR_W-1:0] prod_c, remc;
  logic [RW+STR_W-1:0] remr_f;
  logic [CW+STR_W-1:0] remc_f;
  logic [RW-1:0]      qr_f;
  logic [CW-1:0]      qc_f;
  logic               hit;
  logic [KW-1:0]      dr, dc;
  logic [KW+WW-1:0]   row_back;
  logic [IDX_W-1:0]   widx;

  assign adv = !o_valid || o_ready;

  // horizontal reduction over the window columns
  always_comb begin
    logic [KW-1:0] ix;
    best   = colv[0];
    best_r = colr[0];
    best_c = '0;
    for (int j = 0; j < MAX_KERNEL; j++) begin
      ix = s2_k - KW'(1) - KW'(j);
      if (KW'(j) < s2_k) begin
        if (j == 0) begin
          best   = colv[ix[SLW-1:0]];
          best_r = colr[ix[SLW-1:0]];
          best_c = '0;
        end else if (colv[ix[SLW-1:0]] > best ||
                     (colv[ix[SLW-1:0]] == best && colr[ix[SLW-1:0]] < best_r)) begin
          best   = colv[ix[SLW-1:0]];
          best_r = colr[ix[SLW-1:0]];
          best_c = SLW'(j);
        end
      end
    end
  end

  // quotient estimate by reciprocal, low by at most one
  assign qr_full = RW'(s2_trow) * stride_recip(s2_s);
  assign qc_full = CW'(s2_tcol) * stride_recip(s2_s);

  assign prod_r = s3_qr * s3_s;
  assign prod_c = s3_qc * s3_s;
  assign remr   = (RW+STR_W)'(s3_trow) - prod_r;
  assign remc   = (CW+STR_W)'(s3_tcol) - prod_c;

  always_comb begin
    qr_f   = s4_qr;
    remr_f = s4_remr;
    if (s4_remr >= (RW+STR_W)'(s4_s)) begin
      qr_f   = s4_qr + RW'(1);
      remr_f = s4_remr - (RW+STR_W)'(s4_s);
    end
    qc_f   = s4_qc;
    remc_f = s4_remc;
    if (s4_remc >= (CW+STR_W)'(s4_s)) begin
      qc_f   = s4_qc + CW'(1);
      remc_f = s4_remc - (CW+STR_W)'(s4_s);
    end
  end

  assign hit = s4_ctrl.valid && s4_ctrl.row_ok && s4_ctrl.col_ok &&
               remr_f == '0 && remc_f == '0;
  assign dr       = s4_k - KW'(1) - KW'(s4_wr);
  assign dc       = s4_k - KW'(1) - KW'(s4_wc);
  assign row_back = dr * s4_w;
  assign widx     = s4_cnt - IDX_W'(row_back) - IDX_W'(dc);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctrl <= '0;
      s3_ctrl <= '0;
      s4_ctrl <= '0;
      o_valid <= 1'b0;
    end else if (adv) begin
      s2_ctrl <= in_ctrl;
      s3_ctrl <= s2_ctrl;
      s4_ctrl <= s3_ctrl;
      o_valid <= hit;
    end
    if (adv) begin
      if (in_ctrl.valid) begin
        colv[0] <= in_val;
        colr[0] <= in_vrow;
        for (int b = 1; b < MAX_KERNEL; b++) begin
          colv[b] <= colv[b-1];
          colr[b] <= colr[b-1];
        end
      end
      s2_trow <= in_trow;
      s2_tcol <= in_tcol;
      s2_k    <= in_k;
      s2_s    <= in_s;
      s2_w    <= in_w;
      s2_cnt  <= in_cnt;

      s3_best <= best;
      s3_wr   <= best_r;
      s3_wc   <= best_c;
      s3_qr   <= RW'(qr_full >> RECIP_SH);
      s3_qc   <= CW'(qc_full >> RECIP_SH);
      s3_trow <= s2_trow;
      s3_tcol <= s2_tcol;
      s3_k    <= s2_k;
      s3_s    <= s2_s;
      s3_w    <= s2_w;
      s3_cnt  <= s2_cnt;

      s4_best <= s3_best;
      s4_wr   <= s3_wr;
      s4_wc   <= s3_wc;
      s4_qr   <= s3_qr;
      s4_qc   <= s3_qc;
      s4_remr <= remr;
      s4_remc <= remc;
      s4_k    <= s3_k;
      s4_s    <= s3_s;
      s4_w    <= s3_w;
      s4_cnt  <= s3_cnt;

      if (hit) begin
        o_val  <= s4_best;
        o_idx  <= widx;
        o_row  <= ORC_W'(qr_f);
        o_col  <= ORC_W'(qc_f);
        o_last <= s4_ctrl.plane_end;
      end
    end
  end

  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    $rose(o_valid) |-> $past(s4_ctrl.valid))
    else $error("result without an item in the last stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s4_ctrl) && $stable(s3_ctrl))
    else $error("pipeline moved during a stall");

endmodule

>>> hw/rtl/max_pool_2d_argmax.sv
// channel   dir  width        transaction
// s_axis    in   IN_W         tdata: pixel_value
// m_axis    out  OUT_W + 1    tdata: max_value, winner_index, out_row, out_col; tlast: plane_end
// cfg       in   2 + 11       one register write per cycle with cfg_we
//
// one pixel per cycle unless m_axis stalls; m_axis_tvalid is registered after stages s1 to s4
// the line store reads every row slot of a column together, one bank per row slot
// rst clears position, pixel count and pipeline valids; the line store is not cleared
// a stalled output freezes the whole pipeline and drops s_axis_tready in the same cycle
module max_pool_2d_argmax import mp2d_pkg::*; #(
  parameter int MAX_KERNEL = MP_MAX_KERNEL,
  parameter int MAX_WIDTH  = MP_MAX_WIDTH,
  parameter int MAX_HEIGHT = MP_MAX_HEIGHT,
  parameter int VALUE_BITS = MP_VALUE_BITS,
  localparam int IN_W  = ((VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((VALUE_BITS + IDX_W + 2 * ORC_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // pixel_value
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // max_value, winner_index, out_row, out_col
  output logic              m_axis_tlast
);

  localparam int SLW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WW  = $clog2(MAX_WIDTH + 1);

  logic [KSZ_W-1:0] win_side;
  logic [STR_W-1:0] stride;
  logic [DIM_W-1:0] plane_height;
  logic [DIM_W-1:0] plane_width;

  logic [KW-1:0]    k_eff;
  logic [STR_W-1:0] s_eff;
  logic [HW-1:0]    h_eff;
  logic [WW-1:0]    w_eff;

  logic [RW-1:0]    cur_row, cur_row_next;
  logic [CW-1:0]    cur_col, cur_col_next;
  logic [SLW-1:0]   cur_slot, cur_slot_next;
  logic [IDX_W-1:0] pix_cnt;

  logic [RW-1:0]    pos_r;
  logic [CW-1:0]    pos_c;
  logic [SLW-1:0]   pos_slot;
  logic [RW:0]      r_top;
  logic [CW:0]      c_left;
  logic             plane_end;

  logic             adv, accept;

  mp2d_ctrl_t       s1_ctrl;
  logic signed [VALUE_BITS-1:0] s1_pix;
  logic [SLW-1:0]   s1_slot;
  logic [RW-1:0]    s1_trow;
  logic [CW-1:0]    s1_tcol;
  logic [KW-1:0]    s1_k;
  logic [STR_W-1:0] s1_s;
  logic [WW-1:0]    s1_w;
  logic [IDX_W-1:0] s1_cnt;

  logic [MAX_KERNEL-1:0][VALUE_BITS-1:0] rd_data;
  logic signed [VALUE_BITS-1:0] vm_val;
  logic [SLW-1:0]   vm_row;

  logic [VALUE_BITS-1:0] o_val;
  logic [IDX_W-1:0] o_idx;
  logic [ORC_W-1:0] o_row, o_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_side     <= KSZ_W'(2);
      stride       <= STR_W'(2);
      plane_height <= DIM_W'(32);
      plane_width  <= DIM_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KERNEL: win_side     <= cfg_wdata[KSZ_W-1:0];
        REG_STRIDE: stride       <= cfg_wdata[STR_W-1:0];
        REG_HEIGHT: plane_height <= cfg_wdata[DIM_W-1:0];
        REG_WIDTH:  plane_width  <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_side == '0) k_eff = KW'(1);
    else if (32'(win_side) > MAX_KERNEL) k_eff = KW'(MAX_KERNEL);
    else k_eff = KW'(win_side);
    s_eff = (stride == '0) ? STR_W'(1) : stride;
    if (plane_height == '0) h_eff = HW'(1);
    else if (32'(plane_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(plane_height);
    if (plane_width == '0) w_eff = WW'(1);
    else if (32'(plane_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(plane_width);
  end

  // position of this pixel, then of the next one
  always_comb begin
    logic [RW:0]    rn;
    logic [CW:0]    cn;
    logic [SLW-1:0] sn;
    rn = {1'b0, cur_row};
    cn = {1'b0, cur_col};
    sn = cur_slot;
    if (cn >= (CW+1)'(w_eff)) begin
      cn = '0;
      rn = rn + (RW+1)'(1);
      sn = (sn == SLW'(MAX_KERNEL - 1)) ? '0 : sn + SLW'(1);
    end
    if (rn >= (RW+1)'(h_eff)) begin
      rn = '0;
      sn = '0;
    end
    pos_r    = rn[RW-1:0];
    pos_c    = cn[CW-1:0];
    pos_slot = sn;
    cn = cn + (CW+1)'(1);
    if (cn >= (CW+1)'(w_eff)) begin
      cn = '0;
      rn = rn + (RW+1)'(1);
      sn = (sn == SLW'(MAX_KERNEL - 1)) ? '0 : sn + SLW'(1);
      if (rn >= (RW+1)'(h_eff)) begin
        rn = '0;
        sn = '0;
      end
    end
    cur_row_next  = rn[RW-1:0];
    cur_col_next  = cn[CW-1:0];
    cur_slot_next = sn;
  end

  assign r_top  = (RW+1)'(pos_r) + (RW+1)'(1) - (RW+1)'(k_eff);
  assign c_left = (CW+1)'(pos_c) + (CW+1)'(1) - (CW+1)'(k_eff);
  assign plane_end = ((RW+STR_W+1)'(pos_r) + (RW+STR_W+1)'(s_eff) >= (RW+STR_W+1)'(h_eff)) &&
                     ((CW+STR_W+1)'(pos_c) + (CW+STR_W+1)'(s_eff) >= (CW+STR_W+1)'(w_eff));

  assign accept        = s_axis_tvalid && adv;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_col  <= '0;
      cur_slot <= '0;
      pix_cnt  <= '0;
      s1_ctrl  <= '0;
    end else begin
      if (accept) begin
        cur_row  <= cur_row_next;
        cur_col  <= cur_col_next;
        cur_slot <= cur_slot_next;
        pix_cnt  <= pix_cnt + IDX_W'(1);
      end
      if (adv) begin
        s1_ctrl.valid     <= accept;
        s1_ctrl.row_ok    <= (RW+1)'(pos_r) + (RW+1)'(1) >= (RW+1)'(k_eff);
        s1_ctrl.col_ok    <= (CW+1)'(pos_c) + (CW+1)'(1) >= (CW+1)'(k_eff);
        s1_ctrl.plane_end <= plane_end;
      end
    end
    if (accept) begin
      s1_pix  <= s_axis_tdata[VALUE_BITS-1:0];
      s1_slot <= pos_slot;
      s1_trow <= r_top[RW-1:0];
      s1_tcol <= c_left[CW-1:0];
      s1_k    <= k_eff;
      s1_s    <= s_eff;
      s1_w    <= w_eff;
      s1_cnt  <= pix_cnt;
    end
  end

  // a pixel is written as its column is read; the next read of that column
  // comes in a later cycle, so no forwarding is needed
  mp2d_lbuf #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_lbuf (
    .clk   (clk),
    .we    (accept),
    .wslot (pos_slot),
    .addr  (pos_c),
    .wdata (s_axis_tdata[VALUE_BITS-1:0]),
    .re    (accept),
    .rdata (rd_data)
  );

  // vertical max of this column, top row of the window first
  always_comb begin
    logic [KW-1:0] d;
    logic [KW:0]   sl;
    logic signed [VALUE_BITS-1:0] v;
    vm_val = s1_pix;
    vm_row = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      d  = s1_k - KW'(1) - KW'(i);
      sl = (KW+1)'(s1_slot) + (KW+1)'(MAX_KERNEL) - (KW+1)'(d);
      if (sl >= (KW+1)'(MAX_KERNEL)) sl = sl - (KW+1)'(MAX_KERNEL);
      v = (d == '0) ? s1_pix : $signed(rd_data[sl[SLW-1:0]]);
      if (KW'(i) < s1_k) begin
        if (i == 0 || v > vm_val) begin
          vm_val = v;
          vm_row = SLW'(i);
        end
      end
    end
  end

  mp2d_reduce #(
    .MAX_KERNEL (MAX_KERNEL),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .VALUE_BITS (VALUE_BITS)
  ) u_reduce (
    .clk     (clk),
    .rst     (rst),
    .in_ctrl (s1_ctrl),
    .in_val  (vm_val),
    .in_vrow (vm_row),
    .in_trow (s1_trow),
    .in_tcol (s1_tcol),
    .in_k    (s1_k),
    .in_s    (s1_s),
    .in_w    (s1_w),
    .in_cnt  (s1_cnt),
    .adv     (adv),
    .o_valid (m_axis_tvalid),
    .o_ready (m_axis_tready),
    .o_val   (o_val),
    .o_idx   (o_idx),
    .o_row   (o_row),
    .o_col   (o_col),
    .o_last  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({o_col, o_row, o_idx, o_val});

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cur_slot <= SLW'(MAX_KERNEL - 1))
    else $error("row slot out of range");

  a_vrow_in_window: assert property (@(posedge clk) disable iff (rst)
    s1_ctrl.valid |-> KW'(vm_row) < s1_k)
    else $error("column winner outside the window");

endmodule

>>> bench/tb_max_pool_2d_argmax.sv
`timescale 1ns / 1ps

module tb_max_pool_2d_argmax import mp2d_pkg::*;;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic signed [15:0] max_value;
    logic [31:0]        winner_index;
    logic [9:0]         out_row;
    logic [9:0]         out_col;
    logic               plane_end;
  } pool_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [71:0]       m_axis_tdata;
  logic              m_axis_tlast;

  max_pool_2d_argmax dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always #6 clk = ~clk;

  // shadow of the block state
  logic [3:0]         shadow_kernel = 4'd2;
  logic [3:0]         shadow_stride = 4'd2;
  logic [10:0]        shadow_height = 11'd32;
  logic [10:0]        shadow_width = 11'd32;
  logic signed [15:0] line_mem [0:8191];
  int unsigned        pos_row = 0;
  int unsigned        pos_col = 0;
  logic [31:0]        pixel_count = '0;

  logic signed [15:0] pixel_q [$];
  pool_result_t       window_q [$];
  int                 idle_mode = 0;
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 pixels_taken = 0;
  int                 results_seen = 0;
  int                 config_count = 0;
  bit                 px_done = 1'b0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void pool_pixel(logic signed [15:0] px);
    int unsigned k, s, h, w, r, c, top, left, mr, win_row, win_col;
    logic signed [15:0] m, v, best;
    logic signed [15:0] col_max [0:7];
    int unsigned col_row [0:7];
    pool_result_t res;
    k = clamp_to(shadow_kernel, 8);
    s = clamp_to(shadow_stride, 15);
    h = clamp_to(shadow_height, 1024);
    w = clamp_to(shadow_width, 1024);
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    r = pos_row;
    c = pos_col;
    line_mem[(r % 8) * 1024 + c] = px;
    if (r + 1 >= k && c + 1 >= k && (r + 1 - k) % s == 0 && (c + 1 - k) % s == 0) begin
      top = r + 1 - k;
      left = c + 1 - k;
      for (int j = 0; j < k; j++) begin
        m = line_mem[(top % 8) * 1024 + left + j];
        mr = 0;
        for (int i = 1; i < k; i++) begin
          v = line_mem[((top + i) % 8) * 1024 + left + j];
          if (v > m) begin
            m = v;
            mr = i;
          end
        end
        col_max[j] = m;
        col_row[j] = mr;
      end
      best = col_max[0];
      win_row = col_row[0];
      win_col = 0;
      for (int j = 1; j < k; j++) begin
        if (col_max[j] > best || (col_max[j] == best && col_row[j] < win_row)) begin
          best = col_max[j];
          win_row = col_row[j];
          win_col = j;
        end
      end
      res.max_value = best;
      res.winner_index = pixel_count - 32'((r - top - win_row) * w) - 32'(c - left - win_col);
      res.out_row = 10'((top / s) & 10'h3ff);
      res.out_col = 10'((left / s) & 10'h3ff);
      res.plane_end = (r + s >= h && c + s >= w);
      window_q.push_back(res);
    end
    pixel_count++;
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h) pos_row = 0;
    end
  endfunction

  // monitor and checker
  always @(posedge clk) begin
    pool_result_t exp_res;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (window_q.size() == 0) begin
          $error("result transaction with nothing expected: tdata=%h", m_axis_tdata);
          error_count++;
        end else begin
          exp_res = window_q.pop_front();
          if (m_axis_tdata[15:0] !== exp_res.max_value) begin
            $error("max_value expected %0d got %0d", exp_res.max_value,
                   $signed(m_axis_tdata[15:0]));
            error_count++;
          end
          if (m_axis_tdata[47:16] !== exp_res.winner_index) begin
            $error("winner_index expected %0d got %0d", exp_res.winner_index,
                   m_axis_tdata[47:16]);
            error_count++;
          end
          if (m_axis_tdata[57:48] !== exp_res.out_row) begin
            $error("out_row expected %0d got %0d", exp_res.out_row, m_axis_tdata[57:48]);
            error_count++;
          end
          if (m_axis_tdata[67:58] !== exp_res.out_col) begin
            $error("out_col expected %0d got %0d", exp_res.out_col, m_axis_tdata[67:58]);
            error_count++;
          end
          if (m_axis_tlast !== exp_res.plane_end) begin
            $error("plane_end expected %0d got %0d", exp_res.plane_end, m_axis_tlast);
            error_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pool_pixel(s_axis_tdata);
        pixels_taken++;
        px_done = 1'b1;
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    int send_idle;
    send_idle = (idle_mode == 0) ? 23 : (idle_mode == 1) ? 47 : 0;
    if (!rst && (!s_axis_tvalid || px_done)) begin
      px_done = 1'b0;
      if (pixel_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
        s_axis_tdata <= pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    int recv_idle;
    recv_idle = (idle_mode == 0) ? 47 : (idle_mode == 1) ? 23 : 0;
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic wait_idle();
    while (pixel_q.size() != 0 || s_axis_tvalid || window_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_KERNEL: shadow_kernel = data[3:0];
      REG_STRIDE: shadow_stride = data[3:0];
      REG_HEIGHT: shadow_height = data;
      default:    shadow_width = data;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(int k, int s, int h, int w);
    wait_idle();
    write_reg(REG_KERNEL, CFG_DW'(k));
    write_reg(REG_STRIDE, CFG_DW'(s));
    write_reg(REG_HEIGHT, CFG_DW'(h));
    write_reg(REG_WIDTH, CFG_DW'(w));
    config_count++;
  endtask

  function automatic logic signed [15:0] random_pixel();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 6)) - 3);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // whole planes only, so every phase starts at row 0 column 0
  task automatic random_planes(int k, int s, int h, int w, int planes);
    int hh, ww;
    set_geometry(k, s, h, w);
    hh = clamp_to(h, 1024);
    ww = clamp_to(w, 1024);
    repeat (planes * hh * ww) pixel_q.push_back(random_pixel());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes and ties on a 4x4 plane
    set_geometry(2, 2, 4, 4);
    pixel_q = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0000,
                16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000,
                16'sh8000, 16'sh8000, -16'sd1, 16'sh0100,
                16'sh8000, 16'sh8000, 16'sh0100, 16'sh0100};
    // all-equal window: top-left pixel must win
    set_geometry(3, 1, 3, 3);
    repeat (9) pixel_q.push_back(16'sh0005);
    // kernel wider than plane: no results
    set_geometry(5, 2, 2, 2);
    repeat (4) pixel_q.push_back(16'sh1234);

    random_planes(1, 1, 3, 5, 4);
    random_planes(8, 8, 8, 8, 2);
    random_planes(8, 1, 9, 10, 1);
    idle_mode = 1;
    random_planes(3, 2, 7, 7, 4);
    random_planes(2, 3, 5, 8, 4);
    random_planes(0, 0, 0, 0, 20);
    random_planes(15, 15, 9, 9, 2);
    random_planes(4, 9, 10, 12, 1);
    // sender holds off until everything has drained
    wait_idle();
    idle_mode = 2;
    random_planes(2, 2, 6, 6, 4);
    random_planes(3, 3, 6, 9, 3);

    wait_idle();
    if (window_q.size() != 0) begin
      $error("%0d expected results never arrived", window_q.size());
      error_count++;
    end
    $display("pooled %0d pixels into %0d results across %0d geometries, three idle mixes",
             pixels_taken, results_seen, config_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
